// ===== hdl/w3j_pkg.sv =====
// shared types and constants for the wigner 3j square and sign block
// float unit op codes, request bundle, double constants, small int to double
// no dependencies
package w3j_pkg;

  typedef enum logic [2:0] {
    FOP_MUL = 3'b001,
    FOP_DIV = 3'b010,
    FOP_ADD = 3'b100
  } fpu_op_t;

  typedef struct packed {
    logic    go;
    fpu_op_t op;
  } fpu_req_t;

  localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;

  // small positive integer to double, exact
  function automatic logic [63:0] int_to_double(input logic [7:0] k);
    logic [2:0]  p;
    logic [59:0] sh;
    logic [10:0] e;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[i]) p = 3'(i);
    end
    sh = {52'b0, k} << (6'd52 - {3'b0, p});
    e  = 11'd1023 + {8'b0, p};
    return {1'b0, e, sh[51:0]};
  endfunction

endpackage

// ===== hdl/wigner_3j_racah_square_sign.sv =====
// wigner 3j symbol square and sign by the racah single-sum formula
// after reset a sweep fills the factorial memory, 0! to (3*MAX_TWICE_J/2+1)!,
// during which item_stall stays high
// one item at a time; the time per item grows with the number of racah terms, up to
// nine for MAX_TWICE_J 16, mostly in the radix-2 divides of the shared float unit
// rst is synchronous and returns the block to the factorial sweep
module wigner_3j_racah_square_sign #(
  parameter int MAX_TWICE_J = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [4:0]        twice_j1,
  input  logic [4:0]        twice_j2,
  input  logic [4:0]        twice_j3,
  input  logic signed [5:0] twice_m1,
  input  logic signed [5:0] twice_m2,
  input  logic signed [5:0] twice_m3,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [63:0]       square_bits,
  output logic signed [1:0] symbol_sign
);
  import w3j_pkg::*;

  localparam int FACT_TOP = (3 * MAX_TWICE_J) / 2 + 1;
  localparam int AW       = $clog2(FACT_TOP + 1);

  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;
  localparam logic signed [1:0] SGN_ZERO = 2'sb00;

  typedef enum logic [13:0] {
    ST_INIT_GO   = 14'b00000000000001,
    ST_INIT_WAIT = 14'b00000000000010,
    ST_IDLE      = 14'b00000000000100,
    ST_CHECK     = 14'b00000000001000,
    ST_RD        = 14'b00000000010000,
    ST_USE       = 14'b00000000100000,
    ST_CH_WAIT   = 14'b00000001000000,
    ST_DIV_GO    = 14'b00000010000000,
    ST_DIV_WAIT  = 14'b00000100000000,
    ST_ADD_GO    = 14'b00001000000000,
    ST_ADD_WAIT  = 14'b00010000000000,
    ST_FIN_GO    = 14'b00100000000000,
    ST_FIN_WAIT  = 14'b01000000000000,
    ST_OUT       = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_DELTA = 3'b001,
    PH_PROD  = 3'b010,
    PH_TERM  = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;

  logic [63:0] fact [FACT_TOP + 1];
  logic [63:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] rd_idx;

  logic [AW-1:0] kf;
  logic [2:0]    k;
  logic [2:0]    last_k;
  logic [63:0]   acc, delta, prod, rsum;

  logic [4:0]        xj1, xj2, xj3;
  logic signed [5:0] xm1, xm2, xm3;

  logic signed [7:0] a_r, b_r, c_r, n_r, q1_r, p1_r, p2_r, q4_r, q5_r, q6_r, u_r, v_r;
  logic signed [7:0] lo_r, hi_r, t;
  logic              flip;

  logic signed [7:0] sj1, sj2, sj3, sm1, sm2, sm3;
  logic signed [7:0] ta, tb, tc, tn, tq1, tp1, tp2, tq4, tq5, tq6, tu, tv, tf;
  logic signed [7:0] lo_c, hi_c, idx_sel;
  logic              bad;
  logic signed [1:0] sg_raw, sg_fin;

  fpu_req_t    fpu_req;
  logic [63:0] fpu_a, fpu_b, fpu_res;
  logic        fpu_done;

  function automatic logic signed [7:0] abs8(input logic signed [7:0] x);
    return (x < 8'sd0) ? -x : x;
  endfunction

  w3j_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (fpu_req),
    .opa  (fpu_a),
    .opb  (fpu_b),
    .done (fpu_done),
    .res  (fpu_res)
  );

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_OUT);

  // selection rules and racah arguments
  always_comb begin
    sj1 = $signed({3'b0, xj1});
    sj2 = $signed({3'b0, xj2});
    sj3 = $signed({3'b0, xj3});
    sm1 = 8'(xm1);
    sm2 = 8'(xm2);
    sm3 = 8'(xm3);
    ta  = sj1 + sj2 - sj3;
    tb  = sj1 - sj2 + sj3;
    tc  = sj2 + sj3 - sj1;
    tn  = sj1 + sj2 + sj3;
    tq1 = sj1 + sm1;
    tp1 = sj1 - sm1;
    tp2 = sj2 + sm2;
    tq4 = sj2 - sm2;
    tq5 = sj3 + sm3;
    tq6 = sj3 - sm3;
    tu  = sj3 - sj2 + sm1;
    tv  = sj3 - sj1 - sm2;
    tf  = sj1 - sj2 - sm3;
    bad = (int'(xj1) > MAX_TWICE_J) || (int'(xj2) > MAX_TWICE_J) ||
          (int'(xj3) > MAX_TWICE_J) || (sm1 + sm2 + sm3 != 8'sd0) ||
          (sj3 < abs8(sj1 - sj2)) || (sj3 > sj1 + sj2) || tn[0] ||
          (abs8(sm1) > sj1) || (abs8(sm2) > sj2) || (abs8(sm3) > sj3) ||
          tq1[0] || tp2[0] || tq5[0];
    lo_c = 8'sd0;
    if (-(tu >>> 1) > lo_c) lo_c = -(tu >>> 1);
    if (-(tv >>> 1) > lo_c) lo_c = -(tv >>> 1);
    hi_c = ta >>> 1;
    if ((tp1 >>> 1) < hi_c) hi_c = tp1 >>> 1;
    if ((tp2 >>> 1) < hi_c) hi_c = tp2 >>> 1;
  end

  // factorial index for the current chain step
  always_comb begin
    idx_sel = 8'sd0;
    unique case (phase)
      PH_DELTA: begin
        case (k)
          3'd0:    idx_sel = a_r;
          3'd1:    idx_sel = b_r;
          3'd2:    idx_sel = c_r;
          default: idx_sel = n_r;
        endcase
      end
      PH_PROD: begin
        case (k)
          3'd0:    idx_sel = q1_r;
          3'd1:    idx_sel = p1_r;
          3'd2:    idx_sel = p2_r;
          3'd3:    idx_sel = q4_r;
          3'd4:    idx_sel = q5_r;
          default: idx_sel = q6_r;
        endcase
      end
      PH_TERM: begin
        case (k)
          3'd0:    idx_sel = t;
          3'd1:    idx_sel = a_r - t;
          3'd2:    idx_sel = p1_r - t;
          3'd3:    idx_sel = p2_r - t;
          3'd4:    idx_sel = u_r + t;
          default: idx_sel = v_r + t;
        endcase
      end
      default: idx_sel = 8'sd0;
    endcase
    rd_idx = idx_sel[AW-1:0];
    last_k = (phase == PH_DELTA) ? 3'd3 : 3'd5;
  end

  always_comb begin
    if (rsum[62:0] == 63'd0) begin
      sg_raw = SGN_ZERO;
    end else begin
      sg_raw = rsum[63] ? SGN_NEG : SGN_POS;
    end
    sg_fin = flip ? 2'(-sg_raw) : sg_raw;
  end

  always_comb begin
    fpu_req.go = 1'b0;
    fpu_req.op = FOP_MUL;
    fpu_a      = acc;
    fpu_b      = DBL_ZERO;
    unique case (state)
      ST_INIT_GO: begin
        fpu_req.go = 1'b1;
        fpu_b      = int_to_double(8'(kf));
      end
      ST_USE: begin
        fpu_req.go = (k != 3'd0);
        fpu_req.op = (phase == PH_DELTA && k == 3'd3) ? FOP_DIV : FOP_MUL;
        fpu_b      = rdata;
      end
      ST_DIV_GO: begin
        fpu_req.go = 1'b1;
        fpu_req.op = FOP_DIV;
        fpu_a      = DBL_ONE;
        fpu_b      = acc;
      end
      ST_ADD_GO: begin
        fpu_req.go = 1'b1;
        fpu_req.op = FOP_ADD;
        fpu_a      = rsum;
        fpu_b      = {acc[63] ^ t[0], acc[62:0]};
      end
      ST_FIN_GO: begin
        fpu_req.go = 1'b1;
        fpu_b      = (k == 3'd0) ? prod : rsum;
      end
      default: fpu_req.go = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kf;
    mem_wdata = fpu_res;
    if (state == ST_INIT_GO && kf == AW'(1)) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = DBL_ONE;
    end else if (state == ST_INIT_WAIT && fpu_done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) fact[mem_waddr] <= mem_wdata;
    rdata <= fact[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_GO;
      phase <= PH_DELTA;
      kf    <= AW'(1);
      k     <= '0;
      acc   <= DBL_ONE;
    end else begin
      unique case (state)
        ST_INIT_GO: state <= ST_INIT_WAIT;
        ST_INIT_WAIT: begin
          if (fpu_done) begin
            acc <= fpu_res;
            if (kf == AW'(FACT_TOP)) begin
              state <= ST_IDLE;
            end else begin
              kf    <= kf + AW'(1);
              state <= ST_INIT_GO;
            end
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            xj1   <= twice_j1;
            xj2   <= twice_j2;
            xj3   <= twice_j3;
            xm1   <= twice_m1;
            xm2   <= twice_m2;
            xm3   <= twice_m3;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (bad) begin
            square_bits <= DBL_ZERO;
            symbol_sign <= SGN_ZERO;
            state       <= ST_OUT;
          end else begin
            a_r   <= ta >>> 1;
            b_r   <= tb >>> 1;
            c_r   <= tc >>> 1;
            n_r   <= (tn >>> 1) + 8'sd1;
            q1_r  <= tq1 >>> 1;
            p1_r  <= tp1 >>> 1;
            p2_r  <= tp2 >>> 1;
            q4_r  <= tq4 >>> 1;
            q5_r  <= tq5 >>> 1;
            q6_r  <= tq6 >>> 1;
            u_r   <= tu >>> 1;
            v_r   <= tv >>> 1;
            lo_r  <= lo_c;
            hi_r  <= hi_c;
            flip  <= tf[1];
            rsum  <= DBL_ZERO;
            phase <= PH_DELTA;
            k     <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_USE;
        ST_USE: begin
          if (k == 3'd0) begin
            acc   <= rdata;
            k     <= 3'd1;
            state <= ST_RD;
          end else begin
            state <= ST_CH_WAIT;
          end
        end
        ST_CH_WAIT: begin
          if (fpu_done) begin
            if (k != last_k) begin
              acc   <= fpu_res;
              k     <= k + 3'd1;
              state <= ST_RD;
            end else begin
              unique case (phase)
                PH_DELTA: begin
                  delta <= fpu_res;
                  phase <= PH_PROD;
                  k     <= '0;
                  state <= ST_RD;
                end
                PH_PROD: begin
                  prod <= fpu_res;
                  k    <= '0;
                  if (lo_r <= hi_r) begin
                    t     <= lo_r;
                    phase <= PH_TERM;
                    state <= ST_RD;
                  end else begin
                    acc   <= delta;
                    state <= ST_FIN_GO;
                  end
                end
                PH_TERM: begin
                  acc   <= fpu_res;
                  state <= ST_DIV_GO;
                end
                default: begin
                  acc   <= fpu_res;
                  state <= ST_DIV_GO;
                end
              endcase
            end
          end
        end
        ST_DIV_GO: state <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (fpu_done) begin
            acc   <= fpu_res;
            state <= ST_ADD_GO;
          end
        end
        ST_ADD_GO: state <= ST_ADD_WAIT;
        ST_ADD_WAIT: begin
          if (fpu_done) begin
            rsum <= fpu_res;
            k    <= '0;
            if (t == hi_r) begin
              acc   <= delta;
              state <= ST_FIN_GO;
            end else begin
              t     <= t + 8'sd1;
              state <= ST_RD;
            end
          end
        end
        ST_FIN_GO: state <= ST_FIN_WAIT;
        ST_FIN_WAIT: begin
          if (fpu_done) begin
            acc <= fpu_res;
            if (k == 3'd2) begin
              square_bits <= fpu_res;
              symbol_sign <= sg_fin;
              state       <= ST_OUT;
            end else begin
              k     <= k + 3'd1;
              state <= ST_FIN_GO;
            end
          end
        end
        ST_OUT: begin
          if (!result_stall) state <= ST_IDLE;
        end
        default: state <= ST_INIT_GO;
      endcase
    end
  end

endmodule

// ===== hdl/w3j_fpu.sv =====
// shared double precision unit: multiply, divide, add, round to nearest even
// multiply in three 53x18 partial products, radix-2 divide, one-bit normalize steps
// depends on w3j_pkg
module w3j_fpu (
  input  logic              clk,
  input  logic              rst,
  input  w3j_pkg::fpu_req_t req,
  input  logic [63:0]       opa,
  input  logic [63:0]       opb,
  output logic              done,
  output logic [63:0]       res
);
  import w3j_pkg::*;

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_MUL   = 7'b0000010,
    F_MNORM = 7'b0000100,
    F_DIV   = 7'b0001000,
    F_ALIGN = 7'b0010000,
    F_NORM  = 7'b0100000,
    F_ROUND = 7'b1000000
  } fstate_t;

  fstate_t state;

  logic [52:0]        ma, mb;
  logic [52:0]        xa, xb;
  logic               rsign;
  logic signed [12:0] rexp;
  logic [52:0]        rm;
  logic               rg, rs;
  logic [107:0]       acc;
  logic [1:0]         cnt;
  logic [5:0]         dcnt;
  logic [54:0]        rem;
  logic [53:0]        q;
  logic [55:0]        bigm, smallm;
  logic [10:0]        dexp;
  logic               sub;
  logic [56:0]        sumr;

  logic [53:0]        xb54;
  logic [17:0]        chunk;
  logic [70:0]        partial;
  logic [107:0]       pp;
  logic               ge;
  logic [54:0]        rem_sub, rem_next;
  logic [53:0]        q_next;
  logic [111:0]       dl;
  logic [55:0]        al;
  logic               inc;
  logic [53:0]        rnd;
  logic signed [12:0] fexp;
  logic [51:0]        ffrac;
  logic               a_big;

  assign ma = {1'b1, opa[51:0]};
  assign mb = {1'b1, opb[51:0]};
  assign a_big = opa[62:0] >= opb[62:0];

  always_comb begin
    xb54 = {1'b0, xb};
    case (cnt)
      2'd0:    chunk = xb54[17:0];
      2'd1:    chunk = xb54[35:18];
      default: chunk = xb54[53:36];
    endcase
    partial = xa * chunk;
    case (cnt)
      2'd0:    pp = {37'b0, partial};
      2'd1:    pp = {19'b0, partial, 18'b0};
      default: pp = {1'b0, partial, 36'b0};
    endcase
  end

  always_comb begin
    ge       = rem >= {2'b0, xb};
    rem_sub  = ge ? rem - {2'b0, xb} : rem;
    rem_next = rem_sub << 1;
    q_next   = {q[52:0], ge};
  end

  always_comb begin
    dl = {smallm, 56'b0} >> dexp;
    if (dexp >= 11'd56) begin
      al = 56'd1;
    end else begin
      al = {dl[111:57], dl[56] | (|dl[55:0])};
    end
  end

  always_comb begin
    inc   = rg & (rs | rm[0]);
    rnd   = {1'b0, rm} + {53'b0, inc};
    fexp  = rnd[53] ? rexp + 13'sd1 : rexp;
    ffrac = rnd[53] ? rnd[52:1] : rnd[51:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (req.go) begin
            unique case (req.op)
              FOP_MUL: begin
                if (opa[62:52] == 11'd0 || opb[62:52] == 11'd0) begin
                  res  <= {opa[63] ^ opb[63], 63'b0};
                  done <= 1'b1;
                end else begin
                  xa    <= ma;
                  xb    <= mb;
                  acc   <= '0;
                  cnt   <= '0;
                  rsign <= opa[63] ^ opb[63];
                  rexp  <= 13'($signed({2'b0, opa[62:52]})) +
                           13'($signed({2'b0, opb[62:52]})) - 13'sd1023;
                  state <= F_MUL;
                end
              end
              FOP_DIV: begin
                xb    <= mb;
                rsign <= opa[63] ^ opb[63];
                q     <= '0;
                dcnt  <= '0;
                if (ma < mb) begin
                  rem  <= {1'b0, ma, 1'b0};
                  rexp <= 13'($signed({2'b0, opa[62:52]})) -
                          13'($signed({2'b0, opb[62:52]})) + 13'sd1022;
                end else begin
                  rem  <= {2'b0, ma};
                  rexp <= 13'($signed({2'b0, opa[62:52]})) -
                          13'($signed({2'b0, opb[62:52]})) + 13'sd1023;
                end
                state <= F_DIV;
              end
              FOP_ADD: begin
                if (opa[62:0] == 63'd0) begin
                  res  <= opb;
                  done <= 1'b1;
                end else if (opb[62:0] == 63'd0) begin
                  res  <= opa;
                  done <= 1'b1;
                end else begin
                  sub <= opa[63] ^ opb[63];
                  if (a_big) begin
                    bigm   <= {ma, 3'b0};
                    smallm <= {mb, 3'b0};
                    rsign  <= opa[63];
                    rexp   <= 13'($signed({2'b0, opa[62:52]}));
                    dexp   <= opa[62:52] - opb[62:52];
                  end else begin
                    bigm   <= {mb, 3'b0};
                    smallm <= {ma, 3'b0};
                    rsign  <= opb[63];
                    rexp   <= 13'($signed({2'b0, opb[62:52]}));
                    dexp   <= opb[62:52] - opa[62:52];
                  end
                  state <= F_ALIGN;
                end
              end
              default: state <= F_IDLE;
            endcase
          end
        end
        F_MUL: begin
          acc <= acc + pp;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) state <= F_MNORM;
        end
        F_MNORM: begin
          if (acc[105]) begin
            rm   <= acc[105:53];
            rg   <= acc[52];
            rs   <= |acc[51:0];
            rexp <= rexp + 13'sd1;
          end else begin
            rm <= acc[104:52];
            rg <= acc[51];
            rs <= |acc[50:0];
          end
          state <= F_ROUND;
        end
        F_DIV: begin
          rem  <= rem_next;
          q    <= q_next;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd53) begin
            rm    <= q_next[53:1];
            rg    <= q_next[0];
            rs    <= |rem_next;
            state <= F_ROUND;
          end
        end
        F_ALIGN: begin
          sumr  <= sub ? {1'b0, bigm} - {1'b0, al} : {1'b0, bigm} + {1'b0, al};
          state <= F_NORM;
        end
        F_NORM: begin
          if (sumr == 57'd0) begin
            res   <= DBL_ZERO;
            done  <= 1'b1;
            state <= F_IDLE;
          end else if (sumr[56]) begin
            rm    <= sumr[56:4];
            rg    <= sumr[3];
            rs    <= |sumr[2:0];
            rexp  <= rexp + 13'sd1;
            state <= F_ROUND;
          end else if (sumr[55]) begin
            rm    <= sumr[55:3];
            rg    <= sumr[2];
            rs    <= |sumr[1:0];
            state <= F_ROUND;
          end else begin
            sumr <= sumr << 1;
            rexp <= rexp - 13'sd1;
          end
        end
        F_ROUND: begin
          res   <= {rsign, fexp[10:0], ffrac};
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/w3j_checker.sv =====
// port-level checks for the wigner 3j square and sign block
// bound to the top level; depends only on its ports
module w3j_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic [63:0]       square_bits,
  input logic signed [1:0] symbol_sign
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(square_bits) &&
    $stable(symbol_sign))
    else $error("stalled result beat changed");

  // one item in flight: no new beat while a result waits
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input taken while result pending");

  // a result never leaves in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> !result_valid)
    else $error("result too early");

  // vanishing symbol gives a zero square
  assert property (@(posedge clk) disable iff (rst)
    result_valid && symbol_sign == 2'sb00 |-> square_bits == 64'd0)
    else $error("zero sign with nonzero square");

  // nonzero symbol gives a positive nonzero square
  assert property (@(posedge clk) disable iff (rst)
    result_valid && symbol_sign != 2'sb00 |-> !square_bits[63] && square_bits != 64'd0)
    else $error("bad square for nonzero sign");

endmodule

bind wigner_3j_racah_square_sign w3j_checker u_w3j_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .square_bits  (square_bits),
  .symbol_sign  (symbol_sign)
);
